>>> sv/ppd_pkg.sv
`timescale 1ns / 1ps

package ppd_pkg;

    // Item kinds carried on s_tuser
    localparam logic [2:0] KIND_CAPTURE  = 3'd0;
    localparam logic [2:0] KIND_READ_CH  = 3'd1;
    localparam logic [2:0] KIND_SET_OVR  = 3'd2;
    localparam logic [2:0] KIND_CLR_OVR  = 3'd3;
    localparam logic [2:0] KIND_READ_BLK = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_TIMER_PERIOD = 3'd0;
    localparam logic [2:0] REG_SYNC_GAP     = 3'd1;
    localparam logic [2:0] REG_MIN_CHANNELS = 3'd2;
    localparam logic [2:0] REG_PULSE_FLOOR  = 3'd3;
    localparam logic [2:0] REG_PULSE_CEIL   = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_TIMER_PERIOD = 16'd40000;
    localparam logic [15:0] RST_SYNC_GAP     = 16'd8000;
    localparam logic [3:0]  RST_MIN_CHANNELS = 4'd4;
    localparam logic [15:0] RST_PULSE_FLOOR  = 16'd900;
    localparam logic [15:0] RST_PULSE_CEIL   = 16'd2100;

    typedef struct packed {
        logic accept;   // latch the input transaction
        logic exec;     // apply the item to the decoder state
        logic fetch;    // read one stored channel
        logic load;     // load the output register
        logic advance;  // step to the next channel of a block read
    } ppd_cmd_t;

    typedef struct packed {
        logic need_read;   // item returns stored channel values
        logic has_result;  // item returns at least one result
        logic out_free;    // output register can take a result
        logic last_entry;  // current channel is the final one
    } ppd_status_t;

endpackage

>>> sv/ppd_ctrl.sv
`timescale 1ns / 1ps

module ppd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ppd_pkg::ppd_status_t   status,
    output ppd_pkg::ppd_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.need_read)
                begin
                    state_next = ST_FETCH;
                end
                else if (status.has_result)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    if (status.need_read && !status.last_entry)
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/ppd_datapath.sv
`timescale 1ns / 1ps

module ppd_datapath #(
    parameter int CHANNELS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ppd_pkg::ppd_cmd_t      cmd,
    output ppd_pkg::ppd_status_t   status,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_addr,
    input  logic [15:0]            cfg_wdata,
    input  logic [2:0]             kind,
    input  logic [15:0]            capture_time,
    input  logic [7:0]             channel_index,
    input  logic [15:0]            override_value,
    input  logic [7:0]             read_length,
    output logic [15:0]            pulse_us,
    output logic [3:0]             published_count,
    output logic                   override_taken,
    output logic                   last_of_run,
    output logic                   out_valid,
    input  logic                   out_ready
);

    localparam int CW   = $clog2(CHANNELS + 1);
    localparam int IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMPW = (CW > 4) ? CW : 4;

    // Configuration
    logic [15:0] timer_period_reg;
    logic [15:0] sync_gap_reg;
    logic [3:0]  min_channels_reg;
    logic [15:0] pulse_floor_reg;
    logic [15:0] pulse_ceil_reg;

    // Latched item
    logic [2:0]  kind_reg;
    logic [15:0] cap_reg;
    logic [7:0]  ch_reg;
    logic [15:0] ovr_reg;
    logic [7:0]  len_reg;

    // Decoder state
    logic [15:0] prev_cap_reg;
    logic [CW-1:0] frame_cnt_reg;
    logic [CW-1:0] pub_reg;
    logic [15:0] pulse_store_reg [CHANNELS];
    logic [15:0] ovr_store_reg [CHANNELS];

    // Result build-up
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] last_idx_reg;
    logic [CW-1:0] res_count_reg;
    logic          res_taken_reg;
    logic [15:0]   rd_pulse_reg;
    logic [15:0]   rd_ovr_reg;

    // Output register
    logic          out_valid_reg;
    logic [15:0]   out_pulse_reg;
    logic [3:0]    out_count_reg;
    logic          out_taken_reg;
    logic          out_last_reg;

    logic          ch_in_range;
    logic [7:0]    len_clamped;
    logic [15:0]   wrap_width;
    logic [15:0]   width;
    logic          is_sync;
    logic          frame_open;
    logic [CW-1:0] frame_cnt_inc;
    logic          ovr_taken;
    logic [15:0]   half_width;
    logic [15:0]   clamped;
    logic [15:0]   chan_value;
    logic [CMPW-1:0] count_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_period_reg <= ppd_pkg::RST_TIMER_PERIOD;
            sync_gap_reg     <= ppd_pkg::RST_SYNC_GAP;
            min_channels_reg <= ppd_pkg::RST_MIN_CHANNELS;
            pulse_floor_reg  <= ppd_pkg::RST_PULSE_FLOOR;
            pulse_ceil_reg   <= ppd_pkg::RST_PULSE_CEIL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                ppd_pkg::REG_TIMER_PERIOD: timer_period_reg <= cfg_wdata;
                ppd_pkg::REG_SYNC_GAP:     sync_gap_reg     <= cfg_wdata;
                ppd_pkg::REG_MIN_CHANNELS: min_channels_reg <= cfg_wdata[3:0];
                ppd_pkg::REG_PULSE_FLOOR:  pulse_floor_reg  <= cfg_wdata;
                ppd_pkg::REG_PULSE_CEIL:   pulse_ceil_reg   <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= kind;
            cap_reg  <= capture_time;
            ch_reg   <= channel_index;
            ovr_reg  <= override_value;
            len_reg  <= read_length;
        end
    end

    assign ch_in_range = ch_reg < 8'(CHANNELS);
    assign len_clamped = (len_reg > 8'(CHANNELS)) ? 8'(CHANNELS) : len_reg;

    // Timer wrap: add the period back when the counter rolled over
    assign wrap_width    = cap_reg + timer_period_reg - prev_cap_reg;
    assign width         = (cap_reg < prev_cap_reg) ? wrap_width : cap_reg - prev_cap_reg;
    assign is_sync       = width > sync_gap_reg;
    assign frame_open    = frame_cnt_reg < CW'(CHANNELS);
    assign frame_cnt_inc = frame_cnt_reg + CW'(1);
    assign ovr_taken     = !ovr_reg[15] && ch_in_range && (ovr_reg != 16'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cap_reg  <= '0;
            frame_cnt_reg <= '0;
            pub_reg       <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pulse_store_reg[i] <= '0;
                ovr_store_reg[i]   <= '0;
            end
        end
        else if (cmd.exec)
        begin
            case (kind_reg)
                ppd_pkg::KIND_CAPTURE:
                begin
                    prev_cap_reg <= cap_reg;
                    if (is_sync)
                    begin
                        if (CMPW'(frame_cnt_reg) >= CMPW'(min_channels_reg))
                        begin
                            pub_reg <= frame_cnt_reg;
                        end
                        frame_cnt_reg <= '0;
                    end
                    else if (frame_open)
                    begin
                        pulse_store_reg[frame_cnt_reg[IW-1:0]] <= width;
                        frame_cnt_reg <= frame_cnt_inc;
                        // A full frame publishes without waiting for sync
                        if (frame_cnt_inc == CW'(CHANNELS))
                        begin
                            pub_reg <= CW'(CHANNELS);
                        end
                    end
                end
                ppd_pkg::KIND_READ_CH:
                begin
                    if (ch_in_range)
                    begin
                        pub_reg <= '0;
                    end
                end
                ppd_pkg::KIND_SET_OVR:
                begin
                    if (!ovr_reg[15] && ch_in_range)
                    begin
                        ovr_store_reg[ch_reg[IW-1:0]] <= ovr_reg;
                    end
                    if (ovr_taken)
                    begin
                        pub_reg <= CW'(1);
                    end
                end
                ppd_pkg::KIND_CLR_OVR:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        ovr_store_reg[i] <= '0;
                    end
                end
                ppd_pkg::KIND_READ_BLK:
                begin
                    pub_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_count_reg <= (kind_reg == ppd_pkg::KIND_SET_OVR && ovr_taken) ? CW'(1) : pub_reg;
            res_taken_reg <= (kind_reg == ppd_pkg::KIND_SET_OVR) && ovr_taken;
            if (kind_reg == ppd_pkg::KIND_READ_BLK)
            begin
                idx_reg      <= '0;
                last_idx_reg <= IW'(len_clamped - 8'd1);
            end
            else
            begin
                idx_reg      <= ch_reg[IW-1:0];
                last_idx_reg <= ch_reg[IW-1:0];
            end
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.fetch)
        begin
            rd_pulse_reg <= pulse_store_reg[idx_reg];
            rd_ovr_reg   <= ovr_store_reg[idx_reg];
        end
    end

    // Ticks to microseconds, then clamp; a crossed ceiling wins
    assign half_width = {1'b0, rd_pulse_reg[15:1]};
    assign clamped    = (half_width > pulse_ceil_reg)  ? pulse_ceil_reg :
                        (half_width < pulse_floor_reg) ? pulse_floor_reg : half_width;
    assign chan_value = (rd_ovr_reg != 16'd0) ? rd_ovr_reg : clamped;
    assign count_ext  = CMPW'(res_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_pulse_reg <= status.need_read ? chan_value : 16'd0;
            out_count_reg <= count_ext[3:0];
            out_taken_reg <= res_taken_reg;
            out_last_reg  <= status.need_read ? status.last_entry : 1'b1;
        end
    end

    assign status.need_read  = (kind_reg == ppd_pkg::KIND_READ_CH && ch_in_range) ||
                               (kind_reg == ppd_pkg::KIND_READ_BLK && len_reg != 8'd0);
    assign status.has_result = (kind_reg == ppd_pkg::KIND_READ_CH)  ||
                               (kind_reg == ppd_pkg::KIND_SET_OVR)  ||
                               (kind_reg == ppd_pkg::KIND_CLR_OVR)  ||
                               (kind_reg == ppd_pkg::KIND_READ_BLK);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.last_entry = idx_reg == last_idx_reg;

    assign pulse_us        = out_pulse_reg;
    assign published_count = out_count_reg;
    assign override_taken  = out_taken_reg;
    assign last_of_run     = out_last_reg;
    assign out_valid       = out_valid_reg;

endmodule

>>> sv/ppm_pulse_train_decoder.sv
`timescale 1ns / 1ps

// PPM pulse train decoder. Each capture transaction carries the timer value latched at a
// rising edge; the distance to the previous edge (wrapped at timer_period) is stored as the
// next channel width, or ends the frame when it exceeds sync_gap. Read transactions return
// widths in microseconds, clamped to [pulse_floor, pulse_ceiling], or a nonzero override.
// One item is worked at a time: a capture edge is applied in the exec state, a command
// with a single result goes from exec to the output register, and a read of stored
// channels runs through the shared read path, which fetches one channel and then clamps
// it into the output register. The output register lets the next item enter while the
// last result waits; a stalled m_tready holds back a multi-result read.
module ppm_pulse_train_decoder #(
    parameter int CHANNELS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // capture_time, channel_index, override_value, read_length
    input  logic [2:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pulse_us, published_count, override_taken, zero pad
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    ppd_pkg::ppd_cmd_t    cmd;
    ppd_pkg::ppd_status_t status;

    logic [15:0] pulse_us;
    logic [3:0]  published_count;
    logic        override_taken;

    ppd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ppd_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .kind            (s_tuser),
        .capture_time    (s_tdata[15:0]),
        .channel_index   (s_tdata[23:16]),
        .override_value  (s_tdata[39:24]),
        .read_length     (s_tdata[47:40]),
        .pulse_us        (pulse_us),
        .published_count (published_count),
        .override_taken  (override_taken),
        .last_of_run     (m_tlast),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready)
    );

    assign m_tdata = {3'b000, override_taken, published_count, pulse_us};

    // One item in flight: an accepted transaction closes the input until it is worked off
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // A stored override reports no width and a count of one
    a_override_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[20]) |-> (m_tdata[15:0] == 16'd0 && m_tdata[19:16] == 4'd1
                                       && m_tlast))
        else $error("override result carries wrong fields");

    // Published count never exceeds the channel count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((CHANNELS > 15) || (m_tdata[19:16] <= 4'(CHANNELS))))
        else $error("published count out of range");

endmodule
